// File: hdl/assert_macros.svh
// assertion macros shared by the converter rtl
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define LEC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lec assertion failed");

`define LEC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lec assertion failed");

`else

`define LEC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define LEC_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/lec_pkg.sv
// types and constants of the line ending converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lec_pkg;

    localparam logic [7:0] CH_SUB = 8'h1A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    localparam logic [1:0] REG_ADD_CR_MODE  = 2'd0;
    localparam logic [1:0] REG_AUTO_NEWLINE = 2'd1;

    localparam int QAW    = 2;
    localparam int QDEPTH = 1 << QAW;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_CR    = 2'd1,
        CLS_LF    = 2'd2
    } class_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic add_cr_mode;
        logic auto_newline;
    } cfg_t;

    // bytes[0] goes out first, cnt is 1 to 3
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
    } entry_t;

    typedef struct packed {
        logic           full;
        logic           empty;
        logic [QAW:0]   count;
    } q_status_t;

endpackage

`default_nettype wire

// File: hdl/line_ending_converter_core.sv
// line ending converter: an item enters the front, its bytes leave the back one per cycle
// while m_ready is high; an accepted item's entry is queued and sent after the entries ahead
// throughput: one item per cycle while m_ready is high and items yield at most one byte each;
// an item of several bytes holds the port until all are sent, the 4-entry queue absorbs bursts
// reset: synchronous active low, clears queue and stream state, add_cr_mode 0, auto_newline 1
// depends on lec_pkg, lec_front, lec_queue, lec_back, assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module line_ending_converter_core (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire [1:0]               cfg_index,
    input  wire                     cfg_data,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire lec_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output lec_pkg::out_item_t      m_data
);
    import lec_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    entry_t    push_entry;
    entry_t    head;
    q_status_t q_status;
    logic      push;
    logic      pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_ADD_CR_MODE:  cfg_next.add_cr_mode  = cfg_data;
                REG_AUTO_NEWLINE: cfg_next.auto_newline = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.add_cr_mode  <= 1'b0;
            cfg_reg.auto_newline <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lec_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_full     (q_status.full),
        .push       (push),
        .push_entry (push_entry)
    );

    lec_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    lec_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_empty (q_status.empty),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `LEC_ASSERT_IMP(a_q_bound, aclk, aresetn, 1'b1, q_status.count <= QDEPTH[QAW:0])
    `LEC_ASSERT_IMP(a_no_push_full, aclk, aresetn, push, !q_status.full)
    `LEC_ASSERT_NXT(a_pop_drains, aclk, aresetn, pop && !push,
        q_status.count == $past(q_status.count) - 1'b1)
    `LEC_ASSERT_IMP(a_entry_nonempty, aclk, aresetn, m_valid, head.cnt != 2'd0)

endmodule

`default_nettype wire

// File: hdl/lec_front.sv
// front end: accepts items, tracks line ending state, builds output entries
// depends on lec_pkg
`timescale 1ns / 1ps
`default_nettype none

module lec_front (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire lec_pkg::cfg_t     cfg,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire lec_pkg::in_item_t s_data,
    input  wire                    q_full,
    output logic                   push,
    output lec_pkg::entry_t        push_entry
);
    import lec_pkg::*;

    class_t prev_class_reg, prev_class_next;
    logic   discard_reg, discard_next;
    logic   accept;
    logic   is_end;
    logic   put_prefix;
    logic   put_byte;
    logic   prefix_is_run;
    logic [1:0] pre_cnt;
    logic [7:0] pre_single;
    entry_t e;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign is_end  = s_data.end_of_stream || (!cfg.add_cr_mode && s_data.data_byte == CH_SUB);

    always_comb begin
        prev_class_next = prev_class_reg;
        discard_next    = discard_reg;
        put_prefix      = 1'b0;
        prefix_is_run   = 1'b0;
        put_byte        = 1'b0;
        if (discard_reg) begin
            if (s_data.end_of_stream) begin
                prev_class_next = CLS_OTHER;
                discard_next    = 1'b0;
            end
        end else if (is_end) begin
            case (prev_class_reg)
                CLS_CR: begin
                    put_prefix    = 1'b1;
                    prefix_is_run = 1'b1;
                end
                CLS_LF: put_prefix = 1'b0;
                default: put_prefix = cfg.auto_newline;
            endcase
            prev_class_next = CLS_OTHER;
            discard_next    = !s_data.end_of_stream;
        end else if (s_data.data_byte == CH_CR) begin
            prev_class_next = CLS_CR;
        end else if (s_data.data_byte == CH_LF) begin
            put_prefix      = 1'b1;
            prev_class_next = CLS_LF;
        end else begin
            put_prefix      = (prev_class_reg == CLS_CR);
            prefix_is_run   = 1'b1;
            put_byte        = 1'b1;
            prev_class_next = CLS_OTHER;
        end
    end

    // a cr run in strip mode turns into one byte, everything else into cr lf or lf
    always_comb begin
        pre_single = (prefix_is_run && !cfg.auto_newline) ? CH_CR : CH_LF;
        e          = '0;
        pre_cnt    = 2'd0;
        if (put_prefix) begin
            if (cfg.add_cr_mode) begin
                e.bytes[0] = CH_CR;
                e.bytes[1] = CH_LF;
                pre_cnt    = 2'd2;
            end else begin
                e.bytes[0] = pre_single;
                pre_cnt    = 2'd1;
            end
        end
        e.cnt = pre_cnt;
        if (put_byte) begin
            e.bytes[pre_cnt] = s_data.data_byte;
            e.cnt            = pre_cnt + 2'd1;
        end
    end

    assign push       = accept && (e.cnt != 2'd0);
    assign push_entry = e;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_class_reg <= CLS_OTHER;
            discard_reg    <= 1'b0;
        end else if (accept) begin
            prev_class_reg <= prev_class_next;
            discard_reg    <= discard_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lec_queue.sv
// small queue of output entries between front and back
// depends on lec_pkg
`timescale 1ns / 1ps
`default_nettype none

module lec_queue (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   push,
    input  wire lec_pkg::entry_t  push_entry,
    input  wire                   pop,
    output lec_pkg::entry_t       head,
    output lec_pkg::q_status_t    status
);
    import lec_pkg::*;

    entry_t            mem_reg [QDEPTH];
    logic [QAW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]      count_reg, count_next;
    logic              do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QDEPTH[QAW:0]);
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

`default_nettype wire

// File: hdl/lec_back.sv
// back end: sends the bytes of each queued entry one per cycle while m_ready is high
// depends on lec_pkg
`timescale 1ns / 1ps
`default_nettype none

module lec_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire lec_pkg::entry_t head,
    input  wire                  q_empty,
    output logic                 pop,
    output logic                 m_valid,
    input  wire                  m_ready,
    output lec_pkg::out_item_t   m_data
);
    import lec_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       last;
    logic       take;

    assign m_valid = !q_empty;
    assign last    = (idx_reg == head.cnt - 2'd1);
    assign take    = m_valid && m_ready;
    assign pop     = take && last;

    assign m_data.out_byte    = head.bytes[idx_reg];
    assign m_data.last_of_run = last;

    always_comb begin
        idx_next = idx_reg;
        if (take) begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire
